@@ sv/tga_pkg.sv @@
// Shared types and constants for the totalistic grid automaton.
package tga_pkg;

	localparam int CELL_W       = 2;
	localparam int DELTA_W      = 4;
	localparam int RULE_ENTRIES = 16;
	localparam int RULE_W       = RULE_ENTRIES * DELTA_W;
	localparam int SUM_W        = 4;
	localparam int GEN_W        = 10;

	localparam logic [CELL_W-1:0] CELL_MAX = 2'd3;

	localparam logic [1:0] MODE_WRITE = 2'd0;
	localparam logic [1:0] MODE_STEP  = 2'd1;
	localparam logic [1:0] MODE_READ  = 2'd2;

	typedef struct packed {
		logic [1:0]        mode;
		logic [4:0]        row;
		logic [4:0]        column;
		logic [CELL_W-1:0] cell_in;
		logic [GEN_W-1:0]  generations;
	} cmd_t;

	typedef struct packed {
		logic [CELL_W-1:0] cell_out;
		logic [1:0]        done_mode;
	} rsp_t;

	// Controls shared by every column cell
	typedef struct packed {
		logic              shift;
		logic              first;
		logic              last;
		logic [CELL_W-1:0] wdata;
	} cell_ctrl_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} state_t;

endpackage

@@ sv/totalistic_grid_automaton_core.sv @@
// Top level of the totalistic grid automaton: command control and a chain of column cells.
// Write, read and unused-mode items: the result is registered when the item is accepted;
// one such item per cycle while the result side keeps up.
// Advance items: each generation rotates every column
// once through its cell, one row per cycle. Zero generations answers like a write.
// Reset clears every grid cell and the rule register at once; no clearing pass.
module totalistic_grid_automaton_core #(
	parameter int GRID_SIZE = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cmd_valid,
	output logic                       cmd_stall,
	input  tga_pkg::cmd_t              cmd,
	output logic                       rsp_valid,
	input  logic                       rsp_stall,
	output tga_pkg::rsp_t              rsp,
	input  logic                       rule_we,
	input  logic [tga_pkg::RULE_W-1:0] rule_wdata
);

	localparam int RW = $clog2(GRID_SIZE);
	localparam int AW = (RW > 5) ? RW : 5;
	localparam logic [RW-1:0] LAST_STEP = RW'(GRID_SIZE - 1);

	tga_pkg::state_t             state_q;
	logic [tga_pkg::RULE_W-1:0]  rule_q;
	logic [tga_pkg::GEN_W-1:0]   gen_q;
	logic [RW-1:0]               step_q;
	logic                        rsp_valid_q;
	tga_pkg::rsp_t               rsp_q;

	logic                        accept;
	logic                        in_grid;
	logic [AW-1:0]               row_ext;
	logic [AW-1:0]               col_ext;
	logic [RW-1:0]               row_idx;
	logic [RW-1:0]               col_idx;
	logic                        wr_en;
	logic                        running;
	logic                        finish;
	logic                        rsp_load;
	tga_pkg::rsp_t               rsp_next;
	tga_pkg::cell_ctrl_t         ctrl;

	logic [tga_pkg::CELL_W-1:0]  heads [GRID_SIZE];
	logic [tga_pkg::CELL_W-1:0]  rd_col [GRID_SIZE];

	assign running   = (state_q == tga_pkg::ST_RUN);
	assign cmd_stall = running || (rsp_valid_q && rsp_stall);
	assign accept    = cmd_valid && !cmd_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign row_ext = AW'(cmd.row);
	assign col_ext = AW'(cmd.column);
	assign row_idx = row_ext[RW-1:0];
	assign col_idx = col_ext[RW-1:0];
	assign in_grid = (32'(cmd.row) < GRID_SIZE) && (32'(cmd.column) < GRID_SIZE);
	assign wr_en   = accept && (cmd.mode == tga_pkg::MODE_WRITE) && in_grid;
	assign finish  = running && (step_q == LAST_STEP) && (gen_q == tga_pkg::GEN_W'(1));

	assign ctrl.shift = running;
	assign ctrl.first = (step_q == '0);
	assign ctrl.last  = (step_q == LAST_STEP);
	assign ctrl.wdata = cmd.cell_in;

	always_comb begin
		rsp_load           = 1'b0;
		rsp_next.cell_out  = '0;
		rsp_next.done_mode = cmd.mode;
		if (finish) begin
			rsp_load           = 1'b1;
			rsp_next.done_mode = tga_pkg::MODE_STEP;
		end else if (accept) begin
			case (cmd.mode)
				tga_pkg::MODE_STEP: begin
					rsp_load = (cmd.generations == '0);
				end
				tga_pkg::MODE_READ: begin
					rsp_load = 1'b1;
					if (in_grid) begin
						rsp_next.cell_out = rd_col[col_idx];
					end
				end
				default: begin
					rsp_load = 1'b1;
				end
			endcase
		end
	end

	for (genvar g = 0; g < GRID_SIZE; g++) begin : g_col
		logic [tga_pkg::CELL_W-1:0] left_in;
		logic [tga_pkg::CELL_W-1:0] right_in;

		if (g == 0) begin : g_left_edge
			assign left_in = '0;
		end else begin : g_left
			assign left_in = heads[g-1];
		end
		if (g == GRID_SIZE - 1) begin : g_right_edge
			assign right_in = '0;
		end else begin : g_right
			assign right_in = heads[g+1];
		end

		tga_cell #(
			.N  (GRID_SIZE),
			.RW (RW)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.rule       (rule_q),
			.ctrl       (ctrl),
			.wr_sel     (wr_en && (col_idx == RW'(g))),
			.row_idx    (row_idx),
			.left_head  (left_in),
			.right_head (right_in),
			.head       (heads[g]),
			.rd_data    (rd_col[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rule_q <= '0;
		end else if (rule_we) begin
			rule_q <= rule_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tga_pkg::ST_IDLE;
			gen_q       <= '0;
			step_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			case (state_q)
				tga_pkg::ST_IDLE: begin
					if (accept && (cmd.mode == tga_pkg::MODE_STEP) && (cmd.generations != '0)) begin
						state_q <= tga_pkg::ST_RUN;
						gen_q   <= cmd.generations;
						step_q  <= '0;
					end
				end
				tga_pkg::ST_RUN: begin
					if (step_q == LAST_STEP) begin
						step_q <= '0;
						gen_q  <= gen_q - tga_pkg::GEN_W'(1);
						if (finish) begin
							state_q <= tga_pkg::ST_IDLE;
						end
					end else begin
						step_q <= step_q + RW'(1);
					end
				end
				default: begin
					state_q <= tga_pkg::ST_IDLE;
				end
			endcase

			// Hold the result until taken; a new one may replace it in the same cycle
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_q <= rsp_next;
		end
	end

endmodule

@@ sv/tga_cell.sv @@
// One grid column: a rotating line of cells plus the update rule for its head.
module tga_cell #(
	parameter int N  = 32,
	parameter int RW = 5
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [tga_pkg::RULE_W-1:0]    rule,
	input  tga_pkg::cell_ctrl_t           ctrl,
	input  logic                          wr_sel,
	input  logic [RW-1:0]                 row_idx,
	input  logic [tga_pkg::CELL_W-1:0]    left_head,
	input  logic [tga_pkg::CELL_W-1:0]    right_head,
	output logic [tga_pkg::CELL_W-1:0]    head,
	output logic [tga_pkg::CELL_W-1:0]    rd_data
);

	logic [tga_pkg::CELL_W-1:0]  line_q [N];
	logic [tga_pkg::CELL_W-1:0]  above_q;
	logic [tga_pkg::CELL_W-1:0]  above;
	logic [tga_pkg::CELL_W-1:0]  below;
	logic [tga_pkg::SUM_W-1:0]   sum;
	logic [tga_pkg::DELTA_W-1:0] delta;
	logic signed [4:0]           next_v;
	logic [tga_pkg::CELL_W-1:0]  next_cell;

	assign head    = line_q[0];
	assign rd_data = line_q[row_idx];

	// Grid edges read as zero: no row above the first, none below the last
	assign above = ctrl.first ? '0 : above_q;
	assign below = ctrl.last  ? '0 : line_q[1];

	always_comb begin
		sum = tga_pkg::SUM_W'(head) + tga_pkg::SUM_W'(above) + tga_pkg::SUM_W'(below)
			+ tga_pkg::SUM_W'(left_head) + tga_pkg::SUM_W'(right_head);
		delta  = rule[sum * tga_pkg::DELTA_W +: tga_pkg::DELTA_W];
		next_v = signed'({3'b000, head}) + signed'({delta[tga_pkg::DELTA_W-1], delta});
		if (next_v < 0) begin
			next_cell = '0;
		end else if (next_v > signed'(5'(tga_pkg::CELL_MAX))) begin
			next_cell = tga_pkg::CELL_MAX;
		end else begin
			next_cell = next_v[tga_pkg::CELL_W-1:0];
		end
	end

	// Rotate toward the head; the new row enters at the tail behind the old rows
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < N; i++) begin
				line_q[i] <= '0;
			end
		end else if (ctrl.shift) begin
			for (int i = 0; i < N - 1; i++) begin
				line_q[i] <= line_q[i+1];
			end
			line_q[N-1] <= next_cell;
		end else if (wr_sel) begin
			line_q[row_idx] <= ctrl.wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			above_q <= head;
		end
	end

endmodule

@@ verif/tga_checker.sv @@
// Grid automaton checker: mirrors the grid and rule table, predicts each result and compares.
`timescale 1ns / 1ps

module tga_checker #(
	parameter int GRID_SIZE = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cmd_valid,
	input  logic                       cmd_stall,
	input  tga_pkg::cmd_t              cmd,
	input  logic                       rsp_valid,
	input  logic                       rsp_stall,
	input  tga_pkg::rsp_t              rsp,
	input  logic                       rule_we,
	input  logic [tga_pkg::RULE_W-1:0] rule_wdata,
	output int                         errors,
	output int                         pending
);
	import tga_pkg::*;

	logic [CELL_W-1:0] grid      [GRID_SIZE][GRID_SIZE];
	logic [CELL_W-1:0] grid_next [GRID_SIZE][GRID_SIZE];
	logic [RULE_W-1:0] rule_table;
	rsp_t              expected_rsps [$];

	function automatic int cell_or_zero(int r, int c);
		if (r < 0 || c < 0 || r >= GRID_SIZE || c >= GRID_SIZE)
			return 0;
		return int'(grid[r][c]);
	endfunction

	task automatic run_generations(input int count);
		int sum;
		int delta;
		int v;
		for (int g = 0; g < count; g++) begin
			for (int r = 0; r < GRID_SIZE; r++) begin
				for (int c = 0; c < GRID_SIZE; c++) begin
					sum = cell_or_zero(r, c) + cell_or_zero(r - 1, c) + cell_or_zero(r + 1, c)
						+ cell_or_zero(r, c - 1) + cell_or_zero(r, c + 1);
					delta = $signed(rule_table[sum*DELTA_W +: DELTA_W]);
					v = int'(grid[r][c]) + delta;
					if (v > int'(CELL_MAX))
						v = int'(CELL_MAX);
					if (v < 0)
						v = 0;
					grid_next[r][c] = v[CELL_W-1:0];
				end
			end
			grid = grid_next;
		end
	endtask

	task automatic apply_item(input cmd_t c, output rsp_t r);
		logic in_grid;
		in_grid = (int'(c.row) < GRID_SIZE) && (int'(c.column) < GRID_SIZE);
		r.cell_out  = '0;
		r.done_mode = c.mode;
		case (c.mode)
			MODE_WRITE: begin
				if (in_grid)
					grid[c.row][c.column] = c.cell_in;
			end
			MODE_STEP: begin
				run_generations(int'(c.generations));
			end
			MODE_READ: begin
				if (in_grid)
					r.cell_out = grid[c.row][c.column];
			end
			default: begin
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			foreach (grid[r, c])
				grid[r][c] = '0;
			rule_table = '0;
			expected_rsps.delete();
			errors = 0;
			pending <= 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (expected_rsps.size() == 0) begin
					errors++;
					$display("%0t: unexpected result: expected none, actual cell_out=%0d done_mode=%0d",
						$time, rsp.cell_out, rsp.done_mode);
				end else begin
					want = expected_rsps.pop_front();
					if (rsp.cell_out !== want.cell_out) begin
						errors++;
						$display("%0t: cell_out mismatch: expected %0d, actual %0d",
							$time, want.cell_out, rsp.cell_out);
					end
					if (rsp.done_mode !== want.done_mode) begin
						errors++;
						$display("%0t: done_mode mismatch: expected %0d, actual %0d",
							$time, want.done_mode, rsp.done_mode);
					end
				end
			end
			if (rule_we)
				rule_table = rule_wdata;
			if (cmd_valid && !cmd_stall) begin
				apply_item(cmd, want);
				expected_rsps.push_back(want);
			end
			pending <= expected_rsps.size();
		end
	end

endmodule

@@ verif/tb_totalistic_grid_automaton_core.sv @@
// Testbench top for the grid automaton core: clock, reset, item and rule stimulus, verdict.
`timescale 1ns / 1ps

module tb_totalistic_grid_automaton_core;
	import tga_pkg::*;

	localparam int GRID_SIZE       = 32;
	localparam int PHASES          = 8;
	localparam int ITEMS_PER_PHASE = 110;

	localparam logic [1:0]        MODE_SPARE   = 2'd3;
	localparam logic [RULE_W-1:0] RULE_GROW    = {RULE_ENTRIES{4'h7}};
	localparam logic [RULE_W-1:0] RULE_SHRINK  = {RULE_ENTRIES{4'h8}};
	localparam logic [RULE_W-1:0] RULE_MINUS_1 = {RULE_ENTRIES{4'hF}};

	logic              clk        = 1'b0;
	logic              arst_n     = 1'b0;
	logic              cmd_valid  = 1'b0;
	logic              cmd_stall;
	cmd_t              cmd        = '0;
	logic              rsp_valid;
	logic              rsp_stall  = 1'b0;
	rsp_t              rsp;
	logic              rule_we    = 1'b0;
	logic [RULE_W-1:0] rule_wdata = '0;
	int                errors;
	int                pending;
	bit                steady     = 1'b0;

	always #5 clk = ~clk;

	totalistic_grid_automaton_core #(
		.GRID_SIZE(GRID_SIZE)
	) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.rule_we   (rule_we),
		.rule_wdata(rule_wdata)
	);

	tga_checker #(
		.GRID_SIZE(GRID_SIZE)
	) u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.rule_we   (rule_we),
		.rule_wdata(rule_wdata),
		.errors    (errors),
		.pending   (pending)
	);

	function automatic cmd_t item_of(logic [1:0] mode, int row, int column, int value, int gens);
		cmd_t c;
		c.mode        = mode;
		c.row         = 5'(row);
		c.column      = 5'(column);
		c.cell_in     = CELL_W'(value);
		c.generations = GEN_W'(gens);
		return c;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 60)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic int pick_generations();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(0, 3);
		if (r < 97)
			return $urandom_range(4, 20);
		return $urandom_range(21, 80);
	endfunction

	// Stay near a focus cell so writes, the advance and reads interact
	function automatic int near(int focus);
		int v;
		v = focus + $urandom_range(0, 4) - 2;
		if (v < 0)
			v = 0;
		if (v > GRID_SIZE - 1)
			v = GRID_SIZE - 1;
		return v;
	endfunction

	function automatic int pick_focus();
		if ($urandom_range(0, 3) == 0)
			return ($urandom_range(0, 1) == 0) ? 0 : GRID_SIZE - 1;
		return $urandom_range(0, GRID_SIZE - 1);
	endfunction

	function automatic logic [RULE_W-1:0] mild_rule();
		logic [RULE_W-1:0] r;
		for (int k = 0; k < RULE_ENTRIES; k++)
			r[k*DELTA_W +: DELTA_W] = DELTA_W'($urandom_range(0, 4) - 2);
		return r;
	endfunction

	function automatic cmd_t random_item();
		logic [1:0] mode;
		mode = 2'($urandom_range(0, 3));
		return item_of(mode, $urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 3),
			(mode == MODE_STEP) ? pick_generations() : $urandom_range(0, 1023));
	endfunction

	task automatic send_item(input cmd_t c);
		int gap;
		cmd       <= c;
		cmd_valid <= 1'b1;
		do @(posedge clk); while (cmd_stall);
		gap = pick_gap();
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_idle();
		cmd_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	task automatic load_rule(input logic [RULE_W-1:0] value);
		wait_idle();
		repeat (4) @(posedge clk);
		rule_we    <= 1'b1;
		rule_wdata <= value;
		@(posedge clk);
		rule_we    <= 1'b0;
	endtask

	// Write a small cluster, advance, then read the cluster back
	task automatic run_sequence(inout int sent);
		int fr;
		int fc;
		int k;
		fr = pick_focus();
		fc = pick_focus();
		k  = $urandom_range(1, 6);
		repeat (k)
			send_item(item_of(MODE_WRITE, near(fr), near(fc), $urandom_range(0, 3),
				$urandom_range(0, 1023)));
		send_item(item_of(MODE_STEP, $urandom_range(0, 31), $urandom_range(0, 31),
			$urandom_range(0, 3), pick_generations()));
		repeat (k + 1)
			send_item(item_of(MODE_READ, near(fr), near(fc), $urandom_range(0, 3),
				$urandom_range(0, 1023)));
		sent += 2 * k + 2;
	endtask

	initial begin
		logic [RULE_W-1:0] rule_value;
		int                sent;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Reset grid and zero rule table: reads, a spare-mode item, corner writes and advances
		send_item(item_of(MODE_READ, 0, 0, 3, 1023));
		send_item(item_of(MODE_READ, 31, 31, 0, 0));
		send_item(item_of(MODE_SPARE, 31, 31, 3, 1023));
		send_item(item_of(MODE_WRITE, 0, 0, 3, 0));
		send_item(item_of(MODE_WRITE, 31, 31, 3, 1023));
		send_item(item_of(MODE_WRITE, 0, 31, 2, 0));
		send_item(item_of(MODE_WRITE, 31, 0, 1, 0));
		send_item(item_of(MODE_WRITE, 16, 15, 1, 0));
		send_item(item_of(MODE_READ, 0, 0, 0, 0));
		send_item(item_of(MODE_READ, 31, 31, 0, 0));
		send_item(item_of(MODE_READ, 0, 31, 0, 0));
		send_item(item_of(MODE_READ, 31, 0, 0, 0));
		send_item(item_of(MODE_STEP, 0, 0, 0, 0));
		send_item(item_of(MODE_STEP, 31, 31, 3, 1));
		send_item(item_of(MODE_READ, 16, 15, 0, 0));

		// Clamp toward zero, then toward the maximum
		load_rule(RULE_SHRINK);
		send_item(item_of(MODE_STEP, 0, 0, 0, 1));
		send_item(item_of(MODE_READ, 0, 0, 0, 0));
		send_item(item_of(MODE_READ, 16, 15, 0, 0));
		load_rule(RULE_GROW);
		send_item(item_of(MODE_STEP, 0, 0, 0, 1));
		send_item(item_of(MODE_READ, 31, 31, 0, 0));
		send_item(item_of(MODE_WRITE, 5, 5, 0, 0));
		send_item(item_of(MODE_STEP, 0, 0, 0, 1023));
		send_item(item_of(MODE_READ, 5, 5, 0, 0));
		send_item(item_of(MODE_READ, 0, 31, 0, 0));

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				1:       rule_value = RULE_MINUS_1;
				2, 6:    rule_value = mild_rule();
				3:       rule_value = RULE_GROW;
				5:       rule_value = '0;
				default: rule_value = {$urandom, $urandom};
			endcase
			load_rule(rule_value);
			steady = ($urandom_range(0, 3) == 0);
			sent   = 0;
			while (sent < ITEMS_PER_PHASE) begin
				if ($urandom_range(0, 4) == 0) begin
					send_item(random_item());
					sent++;
				end else begin
					run_sequence(sent);
				end
			end
		end

		wait_idle();
		repeat (10) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Result side: runs of ready cycles broken by short and occasional long stalls
	initial begin
		@(posedge arst_n);
		forever begin
			if (steady || $urandom_range(0, 2) != 0) begin
				rsp_stall <= 1'b0;
				repeat ($urandom_range(1, 20)) @(posedge clk);
			end else begin
				rsp_stall <= 1'b1;
				if ($urandom_range(0, 99) < 85)
					repeat ($urandom_range(1, 3)) @(posedge clk);
				else
					repeat ($urandom_range(10, 40)) @(posedge clk);
			end
		end
	end

	initial begin
		#20_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

@@ totalistic_grid_automaton_core.f @@
sv/tga_pkg.sv
sv/tga_cell.sv
sv/totalistic_grid_automaton_core.sv
verif/tga_checker.sv
verif/tb_totalistic_grid_automaton_core.sv
